// File: src/tcw_pkg.sv
// Package with the shared constants, field widths and operation codes of the text console writer.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int FUNC_W  = 2;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 8;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0a;
  localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;
  localparam logic [CELL_W-1:0]  RESET_CELL   = {RESET_COLOR, BLANK_CODE};

endpackage

// File: src/text_console_writer.sv
// Top level of the text console writer: cursor control, cell memory sequencer and stream ports.
// A printable character or newline that does not scroll, and an unused operation, give their
// result in the cycle after acceptance; a read first passes through the READ state.
// A clear takes one memory write per cell; a scroll reads and then writes each moved cell
// and writes each blanked cell once, all through the single memory port pair.
// One transaction is processed at a time. After reset a pass writes blank cells
// with attribute 07 while in_tready stays low; configuration writes are taken throughout.
module text_console_writer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::COLOR_W-1:0]    cfg_wdata,   // text_color
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [1:0] func, [9:2] char_code, [14:10] read_row, [21:15] read_col, [23:22] zero
  input  logic [tcw_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] read_entry, [20:16] cursor_row, [27:21] cursor_col, [28] scrolled, [31:29] zero
  output logic [tcw_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCR_RD = 3'd3;
  localparam logic [2:0] ST_SCR_WR = 3'd4;
  localparam logic [2:0] ST_BLANK  = 3'd5;

  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_MOVE =
    tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] BOTTOM_ROW =
    tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
  localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
  localparam logic [tcw_pkg::COL_W-1:0] LAST_COL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);

  logic [2:0]                     state_r, state_nxt;
  logic [tcw_pkg::ADDR_W-1:0]     cnt_r, cnt_nxt;
  logic [tcw_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [tcw_pkg::COL_W-1:0]      col_r, col_nxt;
  logic [tcw_pkg::COLOR_W-1:0]    color_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [tcw_pkg::CELL_W-1:0]     entry_r, entry_nxt;
  logic                           scr_r, scr_nxt;
  logic                           rd_ok_r, rd_ok_nxt;

  logic [tcw_pkg::FUNC_W-1:0]     func;
  logic [tcw_pkg::CHAR_W-1:0]     char_code;
  logic [tcw_pkg::ROW_W-1:0]      read_row;
  logic [tcw_pkg::COL_W-1:0]      read_col;

  logic                           accept;
  logic                           we;
  logic [tcw_pkg::ADDR_W-1:0]     waddr, raddr, cursor_addr, read_addr;
  logic [tcw_pkg::CELL_W-1:0]     wdata, rdata, blank_cell;

  assign func      = in_tdata[1:0];
  assign char_code = in_tdata[9:2];
  assign read_row  = in_tdata[14:10];
  assign read_col  = in_tdata[21:15];

  assign in_tready   = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept      = in_tvalid && in_tready;
  assign blank_cell  = {color_r, tcw_pkg::BLANK_CODE};
  assign cursor_addr = tcw_pkg::ADDR_W'(row_r) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                       + tcw_pkg::ADDR_W'(col_r);
  assign read_addr   = tcw_pkg::ADDR_W'(read_row) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                       + tcw_pkg::ADDR_W'(read_col);
  assign raddr       = (state_r == ST_IDLE) ? read_addr
                       : cnt_r + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r && !out_tready;
    entry_nxt     = entry_r;
    scr_nxt       = scr_r;
    rd_ok_nxt     = rd_ok_r;
    we            = 1'b0;
    waddr         = cnt_r;
    wdata         = blank_cell;

    case (state_r)
      ST_INIT: begin
        we    = 1'b1;
        wdata = tcw_pkg::RESET_CELL;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          entry_nxt = '0;
          scr_nxt   = 1'b0;
          case (func)
            tcw_pkg::FUNC_PUT: begin
              if (char_code != tcw_pkg::NEWLINE_CODE) begin
                we    = 1'b1;
                waddr = cursor_addr;
                wdata = {color_r, char_code};
              end
              if (char_code == tcw_pkg::NEWLINE_CODE || col_r == LAST_COL) begin
                col_nxt = '0;
                if (row_r == LAST_ROW) begin
                  scr_nxt   = 1'b1;
                  cnt_nxt   = '0;
                  state_nxt = ST_SCR_RD;
                end else begin
                  row_nxt       = row_r + 1'b1;
                  out_valid_nxt = 1'b1;
                end
              end else begin
                col_nxt       = col_r + 1'b1;
                out_valid_nxt = 1'b1;
              end
            end
            tcw_pkg::FUNC_READ: begin
              rd_ok_nxt = (read_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS)) &&
                          (read_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
              state_nxt = ST_READ;
            end
            tcw_pkg::FUNC_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ST_BLANK;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        entry_nxt     = rd_ok_r ? rdata : '0;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SCR_RD: begin
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        we      = 1'b1;
        wdata   = rdata;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_MOVE) begin
          cnt_nxt   = BOTTOM_ROW;
          state_nxt = ST_BLANK;
        end else begin
          state_nxt = ST_SCR_RD;
        end
      end
      ST_BLANK: begin
        we      = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      color_r     <= tcw_pkg::RESET_COLOR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    scr_r   <= scr_nxt;
    rd_ok_r <= rd_ok_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, scr_r, col_r, row_r, entry_r};

endmodule

// File: src/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/tcw_checker.sv
// Port-level assertion checker for the text console writer and its bind statement.
module tcw_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tcw_pkg::OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result transaction changed while stalled.");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !out_tvalid || out_tready)
    else $error("Input transaction accepted while a result was still blocked.");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[20:16] < tcw_pkg::ROW_W'(tcw_pkg::ROWS) &&
                   out_tdata[27:21] < tcw_pkg::COL_W'(tcw_pkg::COLUMNS))
    else $error("Reported cursor lies outside the screen.");

  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[28] |->
      out_tdata[20:16] == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) &&
      out_tdata[27:21] == '0 && out_tdata[15:0] == '0)
    else $error("Scrolled result does not leave the cursor at the start of the bottom row.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("Block is not quiet straight after reset.");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
